### design/sfs_pkg.sv
package sfs_pkg;

    // Frame table geometry and speed format
    localparam int MAX_FRAMES      = 16;
    localparam int IDX_W           = 4;
    localparam int COUNT_W         = 5;
    localparam int SPEED_FRAC_BITS = 12;
    localparam int SPEED_W         = 16;
    localparam int DT_W            = 16;
    localparam int COORD_W         = 12;
    localparam int OUT_COORD_W     = 13;
    localparam int ACC_W           = 32;
    localparam int PROD_W          = DT_W + SPEED_W;
    localparam int INC_W           = PROD_W - SPEED_FRAC_BITS;

    // Stream and config port widths
    localparam int OP_W            = 3;
    localparam int IN_TDATA_W      = 88;
    localparam int OUT_TDATA_W     = 64;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 32;

    // Reset values of the configuration registers
    localparam logic [ACC_W-1:0]   PERIOD_RST = 32'd100000;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 5'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_WRITE      = 3'd1,
        OP_JUMP       = 3'd2,
        OP_REWIND     = 3'd3,
        OP_SET_PLAY   = 3'd4
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_PERIOD = 3'd0,
        CFG_LOOP_MODE    = 3'd1,
        CFG_FRAME_COUNT  = 3'd2,
        CFG_MIRROR_H     = 3'd3,
        CFG_MIRROR_V     = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        LOOP_STOP      = 2'd0,
        LOOP_WRAP      = 2'd1,
        LOOP_BOOMERANG = 2'd2
    } t_loop_mode;

    // Input item, last field in the lowest bits
    typedef struct packed {
        logic                   play_enable;
        logic [SPEED_W-1:0]     frame_speed;
        logic [COORD_W-1:0]     rect_height;
        logic [COORD_W-1:0]     rect_width;
        logic [COORD_W-1:0]     rect_top;
        logic [COORD_W-1:0]     rect_left;
        logic [IDX_W-1:0]       target_frame;
        logic [DT_W-1:0]        delta_time;
    } t_in_item;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic                          is_playing;
        logic                          frame_dirty;
        logic signed [OUT_COORD_W-1:0] out_height;
        logic signed [OUT_COORD_W-1:0] out_width;
        logic [OUT_COORD_W-1:0]        out_top;
        logic [OUT_COORD_W-1:0]        out_left;
        logic [IDX_W-1:0]              current_index;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_rect;

endpackage

### design/sprite_frame_sequencer_core.sv
// Sprite frame sequencer: takes commands (tick, frame write, jump, rewind,
// play/stop) and returns exactly one result per command, carrying the shown
// frame index, its mirrored source rectangle and change/playing flags.
// A command is captured in the input register, resolved from it once the result
// register is free, and its result is then registered in the result register.
// One command per clock is sustained while the result stream is not stalled;
// the state update (16x16 multiply, saturating accumulate, period compare and
// frame step) is combinational between the input and result registers.
// Configuration writes must only be issued while idle.
// Frame table entries read before being written return undefined data.
module sprite_frame_sequencer_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // delta_time, target_frame, rect_left, rect_top, rect_width, rect_height,
    // frame_speed, play_enable, zero pad
    input  logic [sfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // op
    input  logic [sfs_pkg::OP_W-1:0]        s_axis_tuser,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // current_index, out_left, out_top, out_width, out_height, frame_dirty,
    // is_playing, zero pad
    output logic [sfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // Configuration write port
    input  logic                            i_cfg_wr_en,
    input  logic [sfs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import sfs_pkg::*;

    // Frame tables, no reset
    t_rect              r_rect_table  [MAX_FRAMES];
    logic [SPEED_W-1:0] r_speed_table [MAX_FRAMES];

    // Sequencer state
    logic [IDX_W-1:0]   r_frame_pos;
    logic [ACC_W-1:0]   r_accum;
    logic               r_running;
    logic               r_forward;
    logic               r_change_pending;

    // Configuration
    logic [ACC_W-1:0]   r_frame_period;
    logic [1:0]         r_loop_mode;
    logic [COUNT_W-1:0] r_frame_count;
    logic               r_mirror_h;
    logic               r_mirror_v;

    // Input register and result register
    logic               r_in_valid;
    t_in_item           r_in;
    t_op                r_op;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               out_free;
    logic               proc_en;

    logic [IDX_W-1:0]   n_frame_pos;
    logic [ACC_W-1:0]   n_accum;
    logic               n_running;
    logic               n_forward;
    logic               n_change_pending;
    t_out_item          n_out;

    // Pipeline handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign proc_en       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_out_item))'(0), r_out};

    // Command resolution: next state and result
    always_comb begin
        logic [COUNT_W-1:0] used_frames;
        logic [PROD_W-1:0]  product;
        logic [INC_W-1:0]   increment;
        logic [ACC_W:0]     sum;
        logic [ACC_W-1:0]   sat;
        logic [COUNT_W-1:0] pos_plus;
        t_rect              rect;
        logic [OUT_COORD_W-1:0] w13;
        logic [OUT_COORD_W-1:0] h13;

        n_frame_pos      = r_frame_pos;
        n_accum          = r_accum;
        n_running        = r_running;
        n_forward        = r_forward;
        n_change_pending = r_change_pending;

        // frame_count clamped to 1..MAX_FRAMES
        if (r_frame_count == '0) begin
            used_frames = COUNT_W'(1);
        end else if (r_frame_count > COUNT_W'(MAX_FRAMES)) begin
            used_frames = COUNT_W'(MAX_FRAMES);
        end else begin
            used_frames = r_frame_count;
        end

        // Weighted time increment, saturating accumulate
        product   = PROD_W'(r_in.delta_time) * PROD_W'(r_speed_table[r_frame_pos]);
        increment = product[PROD_W-1:SPEED_FRAC_BITS];
        sum       = {1'b0, r_accum} + (ACC_W+1)'(increment);
        sat       = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
        pos_plus  = {1'b0, r_frame_pos} + COUNT_W'(1);

        unique case (r_op)
            OP_TICK: begin
                if (r_running) begin
                    n_accum = sat;
                    if (sat > r_frame_period) begin
                        n_accum = sat - r_frame_period;
                        // Frame step with end-of-sequence handling
                        if (r_forward && pos_plus < used_frames) begin
                            n_frame_pos      = pos_plus[IDX_W-1:0];
                            n_change_pending = 1'b1;
                        end else if (!r_forward && r_frame_pos != '0) begin
                            n_frame_pos      = r_frame_pos - IDX_W'(1);
                            n_change_pending = 1'b1;
                        end else if (r_loop_mode == LOOP_WRAP) begin
                            n_frame_pos      = r_forward ? '0
                                             : IDX_W'(used_frames - COUNT_W'(1));
                            n_change_pending = 1'b1;
                        end else if (r_loop_mode == LOOP_BOOMERANG) begin
                            n_change_pending = 1'b1;
                            n_forward        = !r_forward;
                            if (used_frames == COUNT_W'(1)) begin
                                n_frame_pos = '0;
                            end else if (!r_forward) begin
                                n_frame_pos = pos_plus[IDX_W-1:0];
                            end else begin
                                n_frame_pos = r_frame_pos - IDX_W'(1);
                            end
                        end else begin
                            n_running = 1'b0;
                        end
                    end
                end
            end
            OP_JUMP: begin
                if (r_in.target_frame != r_frame_pos) begin
                    n_frame_pos      = r_in.target_frame;
                    n_change_pending = 1'b1;
                end
            end
            OP_REWIND: begin
                n_frame_pos      = '0;
                n_accum          = '0;
                n_change_pending = 1'b1;
            end
            OP_SET_PLAY: begin
                n_running = r_in.play_enable;
            end
            default: begin
                // frame write and unused codes leave the sequencer state alone
            end
        endcase

        // Rectangle of the shown frame, forwarding a write to the same entry
        if (r_op == OP_WRITE && r_in.target_frame == n_frame_pos) begin
            rect.left   = r_in.rect_left;
            rect.top    = r_in.rect_top;
            rect.width  = r_in.rect_width;
            rect.height = r_in.rect_height;
        end else begin
            rect = r_rect_table[n_frame_pos];
        end

        w13 = {1'b0, rect.width};
        h13 = {1'b0, rect.height};

        n_out.current_index = n_frame_pos;
        n_out.out_left      = {1'b0, rect.left} + (r_mirror_h ? w13 : '0);
        n_out.out_top       = {1'b0, rect.top} + (r_mirror_v ? h13 : '0);
        n_out.out_width     = r_mirror_h ? (OUT_COORD_W'(0) - w13) : w13;
        n_out.out_height    = r_mirror_v ? (OUT_COORD_W'(0) - h13) : h13;
        n_out.frame_dirty   = n_change_pending;
        n_out.is_playing    = n_running;
    end

    // Frame table writes
    always_ff @(posedge i_clk) begin
        if (proc_en && r_op == OP_WRITE) begin
            r_rect_table[r_in.target_frame].left   <= r_in.rect_left;
            r_rect_table[r_in.target_frame].top    <= r_in.rect_top;
            r_rect_table[r_in.target_frame].width  <= r_in.rect_width;
            r_rect_table[r_in.target_frame].height <= r_in.rect_height;
            r_speed_table[r_in.target_frame]       <= r_in.frame_speed;
        end
    end

    // Input and result payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in <= t_in_item'(s_axis_tdata[$bits(t_in_item)-1:0]);
            r_op <= t_op'(s_axis_tuser);
        end
        if (proc_en) begin
            r_out <= n_out;
        end
    end

    // Control, sequencer state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_frame_pos      <= '0;
            r_accum          <= '0;
            r_running        <= 1'b1;
            r_forward        <= 1'b1;
            r_change_pending <= 1'b1;
            r_frame_period   <= PERIOD_RST;
            r_loop_mode      <= LOOP_WRAP;
            r_frame_count    <= COUNT_RST;
            r_mirror_h       <= 1'b0;
            r_mirror_v       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end

            if (proc_en) begin
                r_frame_pos      <= n_frame_pos;
                r_accum          <= n_accum;
                r_running        <= n_running;
                r_forward        <= n_forward;
                r_change_pending <= 1'b0;
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_FRAME_PERIOD: r_frame_period <= i_cfg_wdata;
                    CFG_LOOP_MODE:    r_loop_mode    <= i_cfg_wdata[1:0];
                    CFG_FRAME_COUNT:  r_frame_count  <= i_cfg_wdata[COUNT_W-1:0];
                    CFG_MIRROR_H: begin
                        r_mirror_h       <= i_cfg_wdata[0];
                        r_change_pending <= 1'b1;
                    end
                    CFG_MIRROR_V: begin
                        r_mirror_v       <= i_cfg_wdata[0];
                        r_change_pending <= 1'b1;
                    end
                    default: begin
                        // writes beyond the register list are dropped
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    // A resolved command always leaves a result in the output register
    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en |=> r_out_valid)
        else $error("resolved command produced no result");

    // The change flag clears once it is reported
    a_change_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en && !i_cfg_wr_en |=> !r_change_pending)
        else $error("change flag not cleared after report");

    // Rewind returns to frame zero with an empty accumulator
    a_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en && r_op == OP_REWIND |=> r_frame_pos == '0 && r_accum == '0)
        else $error("rewind did not reset position and accumulator");

    // The result register only reports the state that was just committed
    a_index_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_en |=> r_out.current_index == r_frame_pos)
        else $error("reported index differs from frame position");
`endif

endmodule

### verif/sfs_frame_checker.sv
`timescale 1ns / 1ps

// Watches the command, result and configuration ports of the sprite frame
// sequencer, keeps its own copy of the sequencer state and checks every result
// transfer against the oldest predicted frame report.
module sfs_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_ready,
    input  logic [sfs_pkg::IN_TDATA_W-1:0]  i_cmd_data,
    input  logic [sfs_pkg::OP_W-1:0]        i_cmd_op,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [sfs_pkg::OUT_TDATA_W-1:0] i_res_data,
    input  logic                            i_cfg_wr_en,
    input  logic [sfs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output int                              o_mismatches,
    output int                              o_outstanding
);

    import sfs_pkg::*;

    // Frame table mirror
    t_rect              frame_rect [MAX_FRAMES];
    logic [SPEED_W-1:0] frame_rate [MAX_FRAMES];

    // Playback state
    logic [IDX_W-1:0] shown_index;
    logic [ACC_W-1:0] weighted_time;
    logic             playing;
    logic             forward;
    logic             change_flag;

    // Register copies
    logic [ACC_W-1:0]   frame_period_q;
    logic [1:0]         loop_sel;
    logic [COUNT_W-1:0] count_sel;
    logic               flip_h;
    logic               flip_v;

    t_out_item expected_frames [$];
    int        mismatch_count = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    function automatic int frames_in_use();
        if (count_sel == 0) return 1;
        if (count_sel > MAX_FRAMES) return MAX_FRAMES;
        return int'(count_sel);
    endfunction

    task automatic reset_state();
        shown_index    = '0;
        weighted_time  = '0;
        playing        = 1'b1;
        forward        = 1'b1;
        change_flag    = 1'b1;
        frame_period_q = PERIOD_RST;
        loop_sel       = LOOP_WRAP;
        count_sel      = COUNT_RST;
        flip_h         = 1'b0;
        flip_v         = 1'b0;
    endtask

    task automatic write_setting(input logic [CFG_ADDR_W-1:0] addr,
                                 input logic [CFG_DATA_W-1:0] data);
        case (addr)
            CFG_FRAME_PERIOD: frame_period_q = data;
            CFG_LOOP_MODE:    loop_sel = data[1:0];
            CFG_FRAME_COUNT:  count_sel = data[COUNT_W-1:0];
            CFG_MIRROR_H: begin
                flip_h      = data[0];
                change_flag = 1'b1;
            end
            CFG_MIRROR_V: begin
                flip_v      = data[0];
                change_flag = 1'b1;
            end
            default: ;
        endcase
    endtask

    // One frame step in the current direction, end of sequence per loop mode
    task automatic step_frame();
        int used;
        int last_idx;
        used     = frames_in_use();
        last_idx = used - 1;
        if (forward && int'(shown_index) + 1 < used) begin
            shown_index = shown_index + 1'b1;
            change_flag = 1'b1;
        end else if (!forward && shown_index != 0) begin
            shown_index = shown_index - 1'b1;
            change_flag = 1'b1;
        end else if (loop_sel == LOOP_WRAP) begin
            shown_index = forward ? '0 : last_idx[IDX_W-1:0];
            change_flag = 1'b1;
        end else if (loop_sel == LOOP_BOOMERANG) begin
            change_flag = 1'b1;
            forward     = !forward;
            // a single frame would otherwise bounce out of the table
            if (used == 1)
                shown_index = '0;
            else if (forward)
                shown_index = shown_index + 1'b1;
            else
                shown_index = shown_index - 1'b1;
        end else begin
            // stop mode, and the undefined mode acting as stop
            playing = 1'b0;
        end
    endtask

    // Speed-weighted time accumulation, saturating, strict compare
    task automatic advance_time(input logic [DT_W-1:0] dt);
        logic [PROD_W-1:0] product;
        logic [ACC_W:0]    total;
        if (playing) begin
            product = {{SPEED_W{1'b0}}, dt} * {{DT_W{1'b0}}, frame_rate[shown_index]};
            total   = {1'b0, weighted_time} + {1'b0, product >> SPEED_FRAC_BITS};
            weighted_time = total[ACC_W] ? '1 : total[ACC_W-1:0];
            if (weighted_time > frame_period_q) begin
                weighted_time = weighted_time - frame_period_q;
                step_frame();
            end
        end
    endtask

    // Apply one command and build the frame report it produces
    task automatic run_command(input logic [OP_W-1:0] op, input t_in_item cmd,
                               output t_out_item report);
        t_rect                  shown;
        logic [OUT_COORD_W-1:0] w13;
        logic [OUT_COORD_W-1:0] h13;
        case (op)
            OP_TICK: advance_time(cmd.delta_time);
            OP_WRITE: begin
                // a 4-bit target always lies inside the table
                frame_rect[cmd.target_frame] = '{left: cmd.rect_left, top: cmd.rect_top,
                                                 width: cmd.rect_width,
                                                 height: cmd.rect_height};
                frame_rate[cmd.target_frame] = cmd.frame_speed;
            end
            OP_JUMP: begin
                if (cmd.target_frame != shown_index) begin
                    shown_index = cmd.target_frame;
                    change_flag = 1'b1;
                end
            end
            OP_REWIND: begin
                shown_index   = '0;
                weighted_time = '0;
                change_flag   = 1'b1;
            end
            OP_SET_PLAY: playing = cmd.play_enable;
            default: ;
        endcase

        shown = frame_rect[shown_index];
        w13   = {1'b0, shown.width};
        h13   = {1'b0, shown.height};
        report.current_index = shown_index;
        report.out_left      = {1'b0, shown.left} + (flip_h ? w13 : '0);
        report.out_top       = {1'b0, shown.top} + (flip_v ? h13 : '0);
        report.out_width     = flip_h ? -w13 : w13;
        report.out_height    = flip_v ? -h13 : h13;
        report.frame_dirty   = change_flag;
        report.is_playing    = playing;
        change_flag = 1'b0;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatch_count++;
        end
    endtask

    // Sample all ports on the rising edge; results are checked before the
    // command of the same edge is predicted
    always @(posedge i_clk) begin
        t_in_item  cmd;
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            reset_state();
            expected_frames.delete();
        end else begin
            if (i_cfg_wr_en)
                write_setting(i_cfg_addr, i_cfg_wdata);

            if (i_res_valid && i_res_ready) begin
                got = i_res_data[$bits(t_out_item)-1:0];
                if (expected_frames.size() == 0) begin
                    $error("result transfer with no frame report pending");
                    mismatch_count++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("current_index", want.current_index, got.current_index);
                    check_field("out_left", want.out_left, got.out_left);
                    check_field("out_top", want.out_top, got.out_top);
                    check_field("out_width", want.out_width, got.out_width);
                    check_field("out_height", want.out_height, got.out_height);
                    check_field("frame_dirty", want.frame_dirty, got.frame_dirty);
                    check_field("is_playing", want.is_playing, got.is_playing);
                end
            end

            if (i_cmd_valid && i_cmd_ready) begin
                cmd = i_cmd_data[$bits(t_in_item)-1:0];
                run_command(i_cmd_op, cmd, want);
                expected_frames.insert(expected_frames.size(), want);
            end
        end
        o_outstanding <= expected_frames.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

### verif/sprite_frame_sequencer_core_tb.sv
`timescale 1ns / 1ps

module sprite_frame_sequencer_core_tb;

    import sfs_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int LATENCY         = 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int HOLD_CYCLES     = 400;

    // loop_mode code with no defined meaning, behaves as stop
    localparam logic [1:0] LOOP_UNDEFINED = 2'd3;

    typedef struct packed {
        logic [ACC_W-1:0]   period;
        logic [1:0]         loop;
        logic [COUNT_W-1:0] count;
        logic               mh;
        logic               mv;
    } t_setting;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int mismatches;
    int outstanding;

    // Idle control shared with the result sink
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int stall_burst   = 0;

    always #10 clk = ~clk;

    sprite_frame_sequencer_core DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata)
    );

    sfs_frame_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cmd_valid   (s_tvalid),
        .i_cmd_ready   (s_tready),
        .i_cmd_data    (s_tdata),
        .i_cmd_op      (s_tuser),
        .i_res_valid   (m_tvalid),
        .i_res_ready   (m_tready),
        .i_res_data    (m_tdata),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_addr    (cfg_addr),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    function automatic logic [COORD_W-1:0] random_coord();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) ? {COORD_W{1'b1}} : '0;
        return COORD_W'($urandom_range(4095));
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        item.delta_time   = ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                                     : 16'($urandom);
        item.target_frame = 4'($urandom_range(MAX_FRAMES - 1));
        item.rect_left    = random_coord();
        item.rect_top     = random_coord();
        item.rect_width   = random_coord();
        item.rect_height  = random_coord();
        case ($urandom_range(7))
            0:       item.frame_speed = '0;
            1:       item.frame_speed = '1;
            2, 3:    item.frame_speed = 16'($urandom_range(3072, 5120));
            default: item.frame_speed = 16'($urandom);
        endcase
        item.play_enable  = ($urandom_range(7) != 0);
        return item;
    endfunction

    // Mostly ticks, with enough play commands to restart a stopped sequence
    function automatic logic [OP_W-1:0] random_op();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return OP_TICK;
        if (pick < 60) return OP_WRITE;
        if (pick < 72) return OP_JUMP;
        if (pick < 76) return OP_REWIND;
        if (pick < 93) return OP_SET_PLAY;
        return OP_W'($urandom_range(OP_SET_PLAY + 1, (1 << OP_W) - 1));
    endfunction

    function automatic t_setting setting_for(int phase);
        case (phase)
            0: return '{32'd2000, LOOP_WRAP, 5'd16, 1'b0, 1'b0};
            1: return '{32'd0, LOOP_BOOMERANG, 5'd5, 1'b1, 1'b0};
            2: return '{32'hFFFF_FFFF, LOOP_STOP, 5'd16, 1'b0, 1'b1};
            3: return '{32'd500, LOOP_BOOMERANG, 5'd1, 1'b1, 1'b1};
            4: return '{32'd3000, LOOP_UNDEFINED, 5'd31, 1'b0, 1'b0};
            5: return '{32'd1, LOOP_WRAP, 5'd0, 1'b1, 1'b0};
            6: return '{32'd200000, LOOP_BOOMERANG, 5'd16, 1'b0, 1'b1};
            default: return '{32'($urandom_range(1, 300000)),
                              2'($urandom_range(LOOP_UNDEFINED)),
                              5'($urandom_range(31)),
                              1'($urandom_range(1)), 1'($urandom_range(1))};
        endcase
    endfunction

    // Write all five registers back to back; only called while idle
    task automatic program_settings(input t_setting s);
        t_cfg_reg         regs [5];
        logic [ACC_W-1:0] vals [5];
        regs = '{CFG_FRAME_PERIOD, CFG_LOOP_MODE, CFG_FRAME_COUNT, CFG_MIRROR_H,
                 CFG_MIRROR_V};
        vals = '{s.period, {30'd0, s.loop}, {27'd0, s.count}, {31'd0, s.mh},
                 {31'd0, s.mv}};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_command(input logic [OP_W-1:0] op, input t_in_item item);
        logic [IN_TDATA_W-1:0] word;
        word = '0;
        word[$bits(t_in_item)-1:0] = item;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Result sink: random stalls, or one long hold-off when requested
    initial begin : result_sink
        int stretch;
        forever begin
            @(posedge clk);
            if (stall_burst != 0) begin
                stretch     = stall_burst;
                stall_burst = 0;
                m_tready <= 1'b0;
                repeat (stretch) @(posedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("sprite_frame_sequencer_core_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        t_in_item item;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the whole table first so no unwritten entry is shown
        program_settings('{32'd1000, LOOP_WRAP, 5'd4, 1'b0, 1'b0});
        for (int f = 0; f < MAX_FRAMES; f++) begin
            item = random_item();
            item.target_frame = 4'(f);
            if (f == 0) begin
                item.rect_left   = '0;
                item.rect_top    = '0;
                item.rect_width  = '1;
                item.rect_height = '1;
                item.frame_speed = 16'd4096;
            end else if (f == 1) begin
                item.rect_left   = '1;
                item.rect_top    = '1;
                item.rect_width  = '1;
                item.rect_height = '1;
                item.frame_speed = '1;
            end else if (f == 2) begin
                item.rect_left   = '0;
                item.rect_top    = '0;
                item.rect_width  = '0;
                item.rect_height = '0;
                item.frame_speed = '0;
            end
            send_command(OP_WRITE, item);
        end
        // full tick at unit speed steps to frame 1, then a jump onto itself
        item = random_item();
        item.delta_time = '1;
        send_command(OP_TICK, item);
        item.target_frame = 4'd1;
        send_command(OP_JUMP, item);
        // jump past the frame count, then step from there
        item.target_frame = 4'd15;
        send_command(OP_JUMP, item);
        send_command(OP_TICK, item);
        send_command(OP_REWIND, item);
        item.play_enable = 1'b0;
        send_command(OP_SET_PLAY, item);
        send_command(OP_TICK, item);
        item.play_enable = 1'b1;
        send_command(OP_SET_PLAY, item);
        for (int op = OP_SET_PLAY + 1; op < (1 << OP_W); op++)
            send_command(OP_W'(op), random_item());
        wait_drained();

        // Random phases, each with its own register setting and idle pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            program_settings(setting_for(phase));
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
            endcase
            // long sink hold-off while commands keep coming, to back up the input
            if (phase == 0)
                stall_burst = HOLD_CYCLES;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_command(random_op(), random_item());
            wait_drained();
        end

        repeat (LATENCY * 4) @(posedge clk);
        if (mismatches == 0)
            $display("sprite_frame_sequencer_core_tb OK");
        else
            $display("sprite_frame_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule

### sprite_frame_sequencer_core.f
design/sfs_pkg.sv
design/sprite_frame_sequencer_core.sv
verif/sfs_frame_checker.sv
verif/sprite_frame_sequencer_core_tb.sv
